@@ src/cmaco_pkg.sv @@
// Package for the miscellaneous-instruction unit: opcode, interrupt-master and
// CPU-entry codes, flag bit positions, and the item and result types.
// No dependencies.
package cmaco_pkg;

    localparam logic [3:0] OP_NOP        = 4'd0;
    localparam logic [3:0] OP_PAD        = 4'd1;
    localparam logic [3:0] OP_EI_NOW     = 4'd2;
    localparam logic [3:0] OP_EI_DELAYED = 4'd3;
    localparam logic [3:0] OP_DI         = 4'd4;
    localparam logic [3:0] OP_STOP       = 4'd5;
    localparam logic [3:0] OP_HALT       = 4'd6;
    localparam logic [3:0] OP_DAA        = 4'd7;
    localparam logic [3:0] OP_CPL        = 4'd8;
    localparam logic [3:0] OP_SCF        = 4'd9;
    localparam logic [3:0] OP_CCF        = 4'd10;

    localparam logic [1:0] IME_OFF = 2'd0;
    localparam logic [1:0] IME_REQ = 2'd1;
    localparam logic [1:0] IME_ON  = 2'd2;
    localparam logic [1:0] IME_BAD = 2'd3;

    localparam logic [1:0] ENTER_NONE = 2'd0;
    localparam logic [1:0] ENTER_HALT = 2'd1;
    localparam logic [1:0] ENTER_STOP = 2'd2;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // Only the five defined interrupt sources count as pending.
    localparam logic [7:0] INT_MASK = 8'h1f;

    localparam logic [7:0] DAA_HI     = 8'h60;
    localparam logic [7:0] DAA_LO     = 8'h06;
    localparam logic [7:0] DAA_HI_MAX = 8'h99;
    localparam logic [3:0] DAA_LO_MAX = 4'h9;

    typedef struct packed {
        logic [3:0] opcode;
        logic [7:0] acc_in;
        logic [3:0] flags_in;
        logic [1:0] ime_in;
        logic [7:0] int_enable;
        logic [7:0] int_flags;
    } item_t;

    typedef struct packed {
        logic [7:0] acc_out;
        logic [3:0] flags_out;
        logic [1:0] ime_out;
        logic       b_write;
        logic [7:0] b_value;
        logic [1:0] cpu_enter;
        logic       halt_bug;
        logic       clear_ie_joypad;
    } result_t;

endpackage

@@ src/cmaco_exec.sv @@
// Combinational execute logic for the miscellaneous instructions: DAA, CPL,
// SCF, CCF, EI/DI, HALT and STOP. Depends on cmaco_pkg.
module cmaco_exec (
    input  cmaco_pkg::item_t   item,
    input  logic               color_model,
    output cmaco_pkg::result_t res
);
    import cmaco_pkg::*;

    logic [1:0] ime;
    logic [7:0] daa_v1;
    logic [7:0] daa_v;
    logic       daa_c;
    logic [3:0] daa_flags;
    logic       irq_pending;

    // Unused master code reads as enabled.
    assign ime = (item.ime_in == IME_BAD) ? IME_ON : item.ime_in;
    assign irq_pending = |(item.int_enable & item.int_flags & INT_MASK);

    always_comb begin
        daa_c  = item.flags_in[FLAG_C];
        daa_v1 = item.acc_in;
        daa_v  = item.acc_in;
        if (item.flags_in[FLAG_N]) begin
            if (item.flags_in[FLAG_C]) begin
                daa_v1 = item.acc_in - DAA_HI;
            end
            daa_v = item.flags_in[FLAG_H] ? (daa_v1 - DAA_LO) : daa_v1;
        end else begin
            if (item.flags_in[FLAG_C] || (item.acc_in > DAA_HI_MAX)) begin
                daa_v1 = item.acc_in + DAA_HI;
                daa_c  = 1'b1;
            end
            // low-nibble test looks at the value after the high correction
            if (item.flags_in[FLAG_H] || (daa_v1[3:0] > DAA_LO_MAX)) begin
                daa_v = daa_v1 + DAA_LO;
            end else begin
                daa_v = daa_v1;
            end
        end
        daa_flags         = item.flags_in;
        daa_flags[FLAG_Z] = (daa_v == 8'd0);
        daa_flags[FLAG_H] = 1'b0;
        daa_flags[FLAG_C] = daa_c;
    end

    always_comb begin
        res.acc_out         = item.acc_in;
        res.flags_out       = item.flags_in;
        res.ime_out         = ime;
        res.b_write         = 1'b0;
        res.b_value         = 8'd0;
        res.cpu_enter       = ENTER_NONE;
        res.halt_bug        = 1'b0;
        res.clear_ie_joypad = 1'b0;
        case (item.opcode)
            OP_EI_NOW: begin
                res.ime_out = IME_ON;
            end
            OP_EI_DELAYED: begin
                res.ime_out = IME_REQ;
            end
            OP_DI: begin
                res.ime_out = IME_OFF;
            end
            OP_STOP: begin
                res.acc_out         = 8'd0;
                res.b_write         = 1'b1;
                res.b_value         = item.int_enable;
                res.clear_ie_joypad = 1'b1;
                res.cpu_enter       = ENTER_STOP;
            end
            OP_HALT: begin
                if ((ime == IME_ON) || !irq_pending) begin
                    res.cpu_enter = ENTER_HALT;
                end else begin
                    res.halt_bug = !color_model;
                end
            end
            OP_DAA: begin
                res.acc_out   = daa_v;
                res.flags_out = daa_flags;
            end
            OP_CPL: begin
                res.acc_out           = ~item.acc_in;
                res.flags_out[FLAG_N] = 1'b1;
                res.flags_out[FLAG_H] = 1'b1;
            end
            OP_SCF: begin
                res.flags_out = {item.flags_in[FLAG_Z], 3'b001};
            end
            OP_CCF: begin
                res.flags_out = {item.flags_in[FLAG_Z], 2'b00, ~item.flags_in[FLAG_C]};
            end
            default: begin
                // nop, pad and unused codes leave everything as is, but an unused IME code reads as enabled
            end
        endcase
    end

endmodule

@@ src/cpu_misc_accumulator_control_ops_core.sv @@
// Top level of the miscellaneous-instruction unit: handshake pipeline,
// configuration register and result register. Depends on cmaco_pkg and
// cmaco_exec.
//
// Usage:
//   Input channel s_*: one instruction (opcode, accumulator, flags, IME state,
//   IE and IF bytes) per transfer. Result channel m_*: new accumulator, flags,
//   IME state, register-B write, HALT/STOP entry, halt-bug mark, IE/P1 clear.
//   APB port: register 0 at byte address 0 holds color_model in bit 0.
//   Path: the input register loads at the transfer edge, and the result
//   register loads from it when the result stage can advance; a result
//   shows on m_* once it sits in the result register.
//   Throughput: one instruction per cycle while m_ready stays high; the decode
//   between the two registers is a single pass of short logic.
//   s_ready falls only when both registers hold items and m_ready is low;
//   a stalled result holds steady on m_* until taken.
//   Reset (aresetn low, synchronous) empties both registers and clears
//   color_model. Write color_model only while no item is in flight.
module cpu_misc_accumulator_control_ops_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_opcode,
    input  logic [7:0]  s_acc_in,
    input  logic [3:0]  s_flags_in,
    input  logic [1:0]  s_ime_in,
    input  logic [7:0]  s_int_enable,
    input  logic [7:0]  s_int_flags,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_acc_out,
    output logic [3:0]  m_flags_out,
    output logic [1:0]  m_ime_out,
    output logic        m_b_write,
    output logic [7:0]  m_b_value,
    output logic [1:0]  m_cpu_enter,
    output logic        m_halt_bug,
    output logic        m_clear_ie_joypad
);
    import cmaco_pkg::*;

    logic    color_model_reg;
    logic    cfg_hit;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t exec_res;
    logic    adv_in;
    logic    adv_out;

    // Configuration port: register 0 only, upper address bit marks out of range.
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == 1'b0);
    assign prdata  = {31'd0, color_model_reg & cfg_hit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_model_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            color_model_reg <= pwdata[0];
        end
    end

    // Two-stage pipeline with ready passed back one stage at a time.
    assign adv_out = !out_valid_reg || m_ready;
    assign adv_in  = !in_valid_reg || adv_out;
    assign s_ready = adv_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv_in) begin
                in_valid_reg <= s_valid;
            end
            if (adv_out) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && adv_in) begin
            in_item_reg <= '{opcode:     s_opcode,
                             acc_in:     s_acc_in,
                             flags_in:   s_flags_in,
                             ime_in:     s_ime_in,
                             int_enable: s_int_enable,
                             int_flags:  s_int_flags};
        end
        if (in_valid_reg && adv_out) begin
            out_res_reg <= exec_res;
        end
    end

    cmaco_exec u_exec (
        .item        (in_item_reg),
        .color_model (color_model_reg),
        .res         (exec_res)
    );

    assign m_valid           = out_valid_reg;
    assign m_acc_out         = out_res_reg.acc_out;
    assign m_flags_out       = out_res_reg.flags_out;
    assign m_ime_out         = out_res_reg.ime_out;
    assign m_b_write         = out_res_reg.b_write;
    assign m_b_value         = out_res_reg.b_value;
    assign m_cpu_enter       = out_res_reg.cpu_enter;
    assign m_halt_bug        = out_res_reg.halt_bug;
    assign m_clear_ie_joypad = out_res_reg.clear_ie_joypad;

    // STOP side effects always travel together.
    a_stop_effects: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_b_write == (m_cpu_enter == ENTER_STOP))
                     && (m_clear_ie_joypad == m_b_write)))
        else $error("STOP side effects out of step");

    // The halt bug is a failed halt, never raised on the color model.
    a_halt_bug: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_halt_bug) |-> ((m_cpu_enter == ENTER_NONE) && !color_model_reg))
        else $error("halt bug raised with halt entry or on color model");

    // A transfer in fills the input register.
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted item lost");

    // b_value carries data only with a register-B write.
    a_b_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_b_write) |-> (m_b_value == 8'd0))
        else $error("b_value set without b_write");

endmodule
